FILE: hw/rtl/ecm_pkg.sv
// Shared types and constants for the edge coverage map.
// Depends on nothing; ecm_front, ecm_back and edge_coverage_map_core refer to it by scoped names.
`default_nettype none

package ecm_pkg;

  // Field widths of the input and result words
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned ADDR_W        = 64;
  localparam int unsigned READ_INDEX_W  = 16;
  localparam int unsigned MAP_INDEX_W   = 16;
  localparam int unsigned HIT_COUNT_W   = 8;

  // Hash shift amounts applied to the block address
  localparam int unsigned HASH_SHIFT_RIGHT = 4;
  localparam int unsigned HASH_SHIFT_LEFT  = 8;

  // Operation codes, equal to the mode field encoding
  typedef enum logic [MODE_W-1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_EMIT   = 4'b1000
  } back_state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/ecm_front.sv
// Front end of the edge coverage map: classifies input words and forms counter indexes.
// Holds the previous-location register; depends on ecm_pkg.
`default_nettype none

module ecm_front #(
  parameter int unsigned MAP_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire logic [ecm_pkg::MODE_W-1:0]         mode_i,
  input  wire logic [ecm_pkg::ADDR_W-1:0]         block_address_i,
  input  wire logic [ecm_pkg::READ_INDEX_W-1:0]   read_index_i,
  output ecm_pkg::op_e                            op_o,
  output logic [MAP_BITS-1:0]                     idx_o
);

  localparam int unsigned PadW =
    (MAP_BITS > ecm_pkg::READ_INDEX_W) ? MAP_BITS : ecm_pkg::READ_INDEX_W;

  logic [MAP_BITS-2:0]            prev_q, prev_d;
  logic [ecm_pkg::ADDR_W-1:0]     hash_full;
  logic [MAP_BITS-1:0]            loc;
  logic [PadW-1:0]                rd_ext;
  ecm_pkg::op_e                   op;

  // Decode mode into an operation
  assign op = ecm_pkg::op_e'(mode_i);

  // Hash the block address and mask to the map size
  assign hash_full = (block_address_i >> ecm_pkg::HASH_SHIFT_RIGHT)
                   ^ (block_address_i << ecm_pkg::HASH_SHIFT_LEFT);
  assign loc       = hash_full[MAP_BITS-1:0];
  assign rd_ext    = PadW'(read_index_i);

  // Pick the counter index for this word
  always_comb begin
    unique case (op)
      ecm_pkg::OP_RECORD: idx_o = loc ^ {1'b0, prev_q};
      ecm_pkg::OP_READ:   idx_o = rd_ext[MAP_BITS-1:0];
      default:            idx_o = '0;
    endcase
  end

  assign op_o = op;

  // Advance the previous location on each accepted record word
  always_comb begin
    prev_d = prev_q;
    if (accept_i && (op == ecm_pkg::OP_RECORD)) begin
      prev_d = loc[MAP_BITS-1:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ecm_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Stores flat words of DATA_W bits; depends on nothing else.
`default_nettype none

module ecm_queue #(
  parameter int unsigned DATA_W = 18
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      pop_data_o
);

  logic [DATA_W-1:0] entry_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the stored words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ecm_back.sv
// Back end of the edge coverage map: counter memory, update sequencer and result register.
// Sweeps the memory clear after reset and on clear words; depends on ecm_pkg.
`default_nettype none

module ecm_back #(
  parameter int unsigned MAP_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_valid_i,
  input  wire ecm_pkg::op_e                      q_op_i,
  input  wire logic [MAP_BITS-1:0]               q_idx_i,
  output logic                                   q_pop_o,
  output logic                                   init_busy_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [ecm_pkg::MAP_INDEX_W-1:0]        map_index_o,
  output logic [ecm_pkg::HIT_COUNT_W-1:0]        hit_count_o
);

  localparam int unsigned Entries = 1 << MAP_BITS;
  localparam int unsigned PadW =
    (MAP_BITS > ecm_pkg::MAP_INDEX_W) ? MAP_BITS : ecm_pkg::MAP_INDEX_W;

  logic [ecm_pkg::HIT_COUNT_W-1:0] mem [Entries];

  ecm_pkg::back_state_e            state_q, state_d;
  ecm_pkg::op_e                    cur_op_q, cur_op_d;
  logic [MAP_BITS-1:0]             cur_idx_q, cur_idx_d;
  logic [MAP_BITS-1:0]             sweep_q, sweep_d;
  logic                            report_q, report_d;
  logic                            out_valid_q, out_valid_d;
  logic [ecm_pkg::MAP_INDEX_W-1:0] map_index_q, map_index_d;
  logic [ecm_pkg::HIT_COUNT_W-1:0] hit_count_q, hit_count_d;
  logic [ecm_pkg::HIT_COUNT_W-1:0] rdata_q;
  logic [ecm_pkg::HIT_COUNT_W-1:0] count_new;
  logic [PadW-1:0]                 cur_idx_ext;

  logic                            rd_en;
  logic                            wr_en;
  logic [MAP_BITS-1:0]             wr_addr;
  logic [ecm_pkg::HIT_COUNT_W-1:0] wr_data;
  logic                            slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cur_idx_ext = PadW'(cur_idx_q);
  assign count_new   = (cur_op_q == ecm_pkg::OP_RECORD) ? rdata_q + 1'b1 : rdata_q;

  // Sequence lookup, update, sweep and result emission
  always_comb begin
    state_d     = state_q;
    cur_op_d    = cur_op_q;
    cur_idx_d   = cur_idx_q;
    sweep_d     = sweep_q;
    report_d    = report_q;
    out_valid_d = out_valid_q && out_stall_i;
    map_index_d = map_index_q;
    hit_count_d = hit_count_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cur_idx_q;
    wr_data     = count_new;

    unique case (state_q)
      ecm_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          cur_op_d  = q_op_i;
          cur_idx_d = q_idx_i;
          unique case (q_op_i)
            ecm_pkg::OP_RECORD, ecm_pkg::OP_READ: begin
              rd_en   = 1'b1;
              state_d = ecm_pkg::ST_LOOKUP;
            end
            ecm_pkg::OP_CLEAR: begin
              sweep_d  = '0;
              report_d = 1'b1;
              state_d  = ecm_pkg::ST_SWEEP;
            end
            default: begin
              state_d = ecm_pkg::ST_EMIT;
            end
          endcase
        end
      end
      ecm_pkg::ST_LOOKUP: begin
        if (slot_free) begin
          wr_en       = (cur_op_q == ecm_pkg::OP_RECORD);
          out_valid_d = 1'b1;
          map_index_d = cur_idx_ext[ecm_pkg::MAP_INDEX_W-1:0];
          hit_count_d = count_new;
          state_d     = ecm_pkg::ST_IDLE;
        end
      end
      ecm_pkg::ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        wr_data = '0;
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q) begin
          state_d = report_q ? ecm_pkg::ST_EMIT : ecm_pkg::ST_IDLE;
        end
      end
      ecm_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          map_index_d = '0;
          hit_count_d = '0;
          report_d    = 1'b0;
          state_d     = ecm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ecm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ecm_pkg::ST_SWEEP;
      sweep_q     <= '0;
      report_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cur_op_q    <= ecm_pkg::OP_NONE;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      report_q    <= report_d;
      out_valid_q <= out_valid_d;
      cur_op_q    <= cur_op_d;
    end
  end

  // Hold payload of the current word and the result
  always_ff @(posedge clk_i) begin
    cur_idx_q   <= cur_idx_d;
    map_index_q <= map_index_d;
    hit_count_q <= hit_count_d;
  end

  // Counter memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[q_idx_i];
    end
  end

  assign init_busy_o = (state_q == ecm_pkg::ST_SWEEP) && !report_q;
  assign out_valid_o = out_valid_q;
  assign map_index_o = map_index_q;
  assign hit_count_o = hit_count_q;

endmodule

`default_nettype wire

FILE: hw/rtl/edge_coverage_map_core.sv
// Edge hit-count coverage map: record, read and clear of 2^MAP_BITS 8-bit counters.
// A record or read word passes the queue, the counter memory read register and the
// result register; the back end takes the next word from the queue only once the
// result is registered. A clear word sweeps every counter to zero, then emits zeros.
// Reset: sweeps the counter memory to zero, stalling input until the sweep ends.
// Depends on ecm_pkg, ecm_front, ecm_queue and ecm_back.
`default_nettype none

module edge_coverage_map_core #(
  parameter int unsigned MAP_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [ecm_pkg::MODE_W-1:0]         mode_i,
  input  wire logic [ecm_pkg::ADDR_W-1:0]         block_address_i,
  input  wire logic [ecm_pkg::READ_INDEX_W-1:0]   read_index_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [ecm_pkg::MAP_INDEX_W-1:0]         map_index_o,
  output logic [ecm_pkg::HIT_COUNT_W-1:0]         hit_count_o
);

  localparam int unsigned WordW = ecm_pkg::MODE_W + MAP_BITS;

  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic                init_busy;
  logic                in_accept;
  ecm_pkg::op_e        front_op;
  logic [MAP_BITS-1:0] front_idx;
  logic [WordW-1:0]    push_word;
  logic [WordW-1:0]    pop_word;
  ecm_pkg::op_e        q_op;
  logic [MAP_BITS-1:0] q_idx;

  // Stall input while the queue is full or the map is being cleared after reset
  assign in_stall_o = q_full || init_busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  ecm_front #(
    .MAP_BITS(MAP_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .mode_i          (mode_i),
    .block_address_i (block_address_i),
    .read_index_i    (read_index_i),
    .op_o            (front_op),
    .idx_o           (front_idx)
  );

  // Pack and unpack the queued word
  assign push_word = {front_op, front_idx};
  assign q_op      = ecm_pkg::op_e'(pop_word[WordW-1:MAP_BITS]);
  assign q_idx     = pop_word[MAP_BITS-1:0];

  ecm_queue #(
    .DATA_W(WordW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_word)
  );

  ecm_back #(
    .MAP_BITS(MAP_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_idx_i     (q_idx),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .map_index_o (map_index_o),
    .hit_count_o (hit_count_o)
  );

endmodule

`default_nettype wire

FILE: dv/edge_coverage_map_core_tb.sv
// Self-checking testbench for edge_coverage_map_core: words of every mode are driven
// over valid/stall and every result word is checked against a built-in predictor.
// Depends on ecm_pkg and edge_coverage_map_core.
`timescale 1ns / 100ps

module edge_coverage_map_core_tb;
  import ecm_pkg::*;

  localparam int unsigned MAP_BITS    = 16;
  localparam int unsigned MAP_ENTRIES = 1 << MAP_BITS;
  localparam int unsigned IDLE_PCT    = 7;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [MAP_INDEX_W-1:0] map_index;
    logic [HIT_COUNT_W-1:0] hit_count;
  } hit_word_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic [MODE_W-1:0]       mode_i          = '0;
  logic [ADDR_W-1:0]       block_address_i = '0;
  logic [READ_INDEX_W-1:0] read_index_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic [MAP_INDEX_W-1:0]  map_index_o;
  logic [HIT_COUNT_W-1:0]  hit_count_o;

  // Predictor state: counter array and hashed previous location
  logic [HIT_COUNT_W-1:0]  counter_shadow [0:MAP_ENTRIES-1];
  logic [MAP_BITS-2:0]     prev_loc_shadow;

  hit_word_t               pending_hits [$];
  logic [MAP_INDEX_W-1:0]  touched_idx_q [$];
  logic [MAP_INDEX_W-1:0]  last_record_index = '0;
  hit_word_t               exp_word;

  bit                      steady_flow = 1'b0;
  int unsigned             error_count = 0;
  int unsigned             cycle_count = 0;
  int unsigned             n_record    = 0;
  int unsigned             n_read      = 0;
  int unsigned             n_clear     = 0;
  int unsigned             n_none      = 0;
  int unsigned             n_wraps     = 0;

  edge_coverage_map_core #(
    .MAP_BITS(MAP_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .block_address_i(block_address_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .map_index_o    (map_index_o),
    .hit_count_o    (hit_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one word to the shadow map and return the result word it should produce
  function automatic hit_word_t predict_edge_hit(op_e op, logic [ADDR_W-1:0] pc,
                                                 logic [READ_INDEX_W-1:0] rd_idx);
    hit_word_t             w;
    logic [ADDR_W-1:0]     mixed;
    logic [MAP_BITS-1:0]   loc;
    logic [MAP_BITS-1:0]   idx;
    w = '0;
    case (op)
      OP_RECORD: begin
        mixed = (pc >> HASH_SHIFT_RIGHT) ^ (pc << HASH_SHIFT_LEFT);
        loc = mixed[MAP_BITS-1:0];
        idx = loc ^ {1'b0, prev_loc_shadow};
        counter_shadow[idx] = counter_shadow[idx] + 1'b1;
        w.map_index = idx[MAP_INDEX_W-1:0];
        w.hit_count = counter_shadow[idx];
        prev_loc_shadow = loc[MAP_BITS-1:1];
      end
      OP_READ: begin
        idx = rd_idx[MAP_BITS-1:0];
        w.map_index = idx[MAP_INDEX_W-1:0];
        w.hit_count = counter_shadow[idx];
      end
      OP_CLEAR: begin
        for (int i = 0; i < MAP_ENTRIES; i++) counter_shadow[i] = '0;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Drive one word, hold it until accepted, then log its expected result
  task automatic send_word(op_e op, logic [ADDR_W-1:0] pc, logic [READ_INDEX_W-1:0] rd_idx);
    hit_word_t w;
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= op;
    block_address_i <= pc;
    read_index_i    <= rd_idx;
    do @(posedge clk_i); while (in_stall_o);
    w = predict_edge_hit(op, pc, rd_idx);
    pending_hits.insert(pending_hits.size(), w);
    case (op)
      OP_RECORD: begin
        n_record++;
        if (w.hit_count == '0) n_wraps++;
        last_record_index = w.map_index;
        touched_idx_q.insert(touched_idx_q.size(), w.map_index);
        if (touched_idx_q.size() > 64) touched_idx_q.delete(0);
      end
      OP_READ:  n_read++;
      OP_CLEAR: n_clear++;
      default:  n_none++;
    endcase
  endtask

  // Hold off the sender until every outstanding result word has arrived
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [READ_INDEX_W-1:0] pick_touched_index();
    if (touched_idx_q.size() == 0) return READ_INDEX_W'($urandom);
    return touched_idx_q[$urandom_range(touched_idx_q.size() - 1)];
  endfunction

  // Field extremes, every mode, clear behavior and the unused mode
  task automatic test_directed();
    send_word(OP_RECORD, 64'h0, 16'h0);
    send_word(OP_RECORD, 64'h0, 16'h0);
    send_word(OP_RECORD, '1, 16'h0);
    send_word(OP_RECORD, 64'h8000_0000_0000_0000, 16'h0);
    send_word(OP_RECORD, 64'h0000_0000_0000_FFFF, 16'h0);
    send_word(OP_RECORD, 64'h0000_0000_000F_FFF0, 16'h0);
    send_word(OP_RECORD, 64'h5555_5555_5555_5555, 16'h0);
    send_word(OP_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, '1);
    send_word(OP_READ, '1, 16'h0000);
    send_word(OP_READ, 64'h0, 16'hFFFF);
    send_word(OP_READ, 64'h0, last_record_index);
    send_word(OP_READ, 64'h0, 16'h5555);
    send_word(OP_READ, 64'h0, 16'hAAAA);
    send_word(OP_NONE, '1, '1);
    send_word(OP_NONE, 64'h0, 16'h0);
    send_word(OP_CLEAR, '1, '1);
    send_word(OP_READ, 64'h0, last_record_index);
    send_word(OP_RECORD, 64'h0, 16'h0);
    send_word(OP_READ, 64'h0, 16'h0);
  endtask

  // Spin one block in a tight loop so its self-edge counter wraps past 255
  task automatic test_counter_wrap();
    logic [ADDR_W-1:0] loop_pc;
    loop_pc = {$urandom, $urandom};
    steady_flow = 1'b1;
    repeat (300) send_word(OP_RECORD, loop_pc, READ_INDEX_W'($urandom));
    send_word(OP_READ, loop_pc, last_record_index);
    steady_flow = 1'b0;
  endtask

  // Walk a small random control-flow graph with reads, clears and a full drain mixed in
  task automatic test_trace_walk();
    logic [ADDR_W-1:0] program_pcs [0:15];
    int unsigned       n_blocks;
    int unsigned       roll;
    n_blocks = $urandom_range(4, 16);
    for (int i = 0; i < 16; i++) program_pcs[i] = {$urandom, $urandom};
    for (int k = 0; k < 800; k++) begin
      if (k == 270 || k == 540) send_word(OP_CLEAR, {$urandom, $urandom}, READ_INDEX_W'($urandom));
      if (k == 400) wait_results_drained();
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_word(OP_RECORD, program_pcs[$urandom_range(n_blocks - 1)], READ_INDEX_W'($urandom));
      end else if (roll < 85) begin
        send_word(OP_READ, {$urandom, $urandom}, pick_touched_index());
      end else if (roll < 92) begin
        send_word(OP_READ, {$urandom, $urandom}, READ_INDEX_W'($urandom));
      end else if (roll < 97) begin
        send_word(OP_RECORD, {$urandom, $urandom}, READ_INDEX_W'($urandom));
      end else begin
        send_word(OP_NONE, {$urandom, $urandom}, READ_INDEX_W'($urandom));
      end
    end
  endtask

  // Fully random fields without clears
  task automatic test_random_noise();
    int unsigned roll;
    repeat (200) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        send_word(OP_RECORD, {$urandom, $urandom}, READ_INDEX_W'($urandom));
      end else if (roll < 90) begin
        send_word(OP_READ, {$urandom, $urandom}, READ_INDEX_W'($urandom));
      end else begin
        send_word(OP_NONE, {$urandom, $urandom}, READ_INDEX_W'($urandom));
      end
    end
  endtask

  // Stall the result side at random and compare each accepted result word
  always @(posedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result word: map_index %h hit_count %h",
                 $time, map_index_o, hit_count_o);
        error_count++;
      end else begin
        exp_word = pending_hits[0];
        pending_hits.delete(0);
        if (map_index_o !== exp_word.map_index) begin
          $display("%0t: map_index mismatch: expected %h, got %h",
                   $time, exp_word.map_index, map_index_o);
          error_count++;
        end
        if (hit_count_o !== exp_word.hit_count) begin
          $display("%0t: hit_count mismatch: expected %h, got %h",
                   $time, exp_word.hit_count, hit_count_o);
          error_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result words outstanding",
               cycle_count, pending_hits.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAP_ENTRIES; i++) counter_shadow[i] = '0;
    prev_loc_shadow = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_counter_wrap();
    test_trace_walk();
    test_random_noise();
    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Covered %0d record, %0d read, %0d clear and %0d unused-mode words,",
             n_record, n_read, n_clear, n_none);
    $display("with %0d counter wraps and %0d mismatches.", n_wraps, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
